FILE: src/stt_pkg.sv
`timescale 1ns / 1ps

package stt_pkg;

	typedef enum logic [2:0] {
		ST_BEGIN      = 3'd0,
		ST_COMMENT    = 3'd1,
		ST_SECTION    = 3'd2,
		ST_FIELD      = 3'd3,
		ST_VALUE      = 3'd4,
		ST_VALUE_ESC  = 3'd5,
		ST_VALUE_JOIN = 3'd6,
		ST_SIGNATURE  = 3'd7
	} parse_state_t;

	typedef logic [3:0] event_t;

	localparam event_t EV_SECTION_BYTE = 4'd0;
	localparam event_t EV_FIELD_BYTE   = 4'd1;
	localparam event_t EV_VALUE_BYTE   = 4'd2;
	localparam event_t EV_SECTION_DONE = 4'd3;
	localparam event_t EV_FIELD_DONE   = 4'd4;
	localparam event_t EV_VALUE_DONE   = 4'd5;
	localparam event_t EV_END_SECTION  = 4'd6;
	localparam event_t EV_SIG_OK       = 4'd7;
	localparam event_t EV_SIG_BAD      = 4'd8;
	localparam event_t EV_ABORTED      = 4'd9;

	localparam logic [3:0] SIG_LAST_IDX = 4'd10;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_LBR   = 8'h7B;
	localparam logic [7:0] CH_RBR   = 8'h7D;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		event_t     ev;
		logic [7:0] data;
		logic       last;
	} result_t;

	// Up to two results per input byte, first in r0.
	typedef struct packed {
		logic [1:0] num;
		result_t    r0;
		result_t    r1;
	} result_pair_t;

	typedef struct packed {
		logic              room;
		logic [QCNT_W-1:0] count;
	} queue_status_t;

	function automatic logic [7:0] sig_char(input logic [3:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0:    ch = 8'h64; // d
			4'd1:    ch = 8'h62; // b
			4'd2:    ch = 8'h77; // w
			4'd3:    ch = 8'h33; // 3
			4'd4:    ch = 8'h3A; // :
			4'd5:    ch = 8'h66; // f
			4'd6:    ch = 8'h69; // i
			4'd7:    ch = 8'h6C; // l
			4'd8:    ch = 8'h65; // e
			4'd9:    ch = CH_CR;
			default: ch = CH_LF;
		endcase
		return ch;
	endfunction

endpackage

FILE: src/stt_parse.sv
`timescale 1ns / 1ps

module stt_parse import stt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         adv,
	input  logic [7:0]   cur_byte,
	output result_pair_t res
);

	parse_state_t st_q, st_d;
	logic [3:0]   cnt_q, cnt_d;
	logic         match_q, match_d;

	logic       is_eol, is_blank, abort, sig_hit;
	logic [3:0] idx;

	assign is_eol   = (cur_byte == CH_CR) || (cur_byte == CH_LF);
	assign is_blank = (cur_byte == CH_SPACE) || (cur_byte == CH_TAB);
	// Bytes after the first one of a signature are plain data, zero included.
	assign abort    = (cur_byte == CH_NUL) && !((st_q == ST_SIGNATURE) && (cnt_q != 4'd0));
	assign idx      = (cnt_q > SIG_LAST_IDX) ? SIG_LAST_IDX : cnt_q;
	assign sig_hit  = (cur_byte == sig_char(idx));

	always_comb begin
		st_d    = st_q;
		cnt_d   = cnt_q;
		match_d = match_q;
		if (abort) begin
			st_d = ST_BEGIN;
		end else begin
			case (st_q)
				ST_BEGIN: begin
					if (is_blank || is_eol) begin
						st_d = ST_BEGIN;
					end else if (cur_byte == CH_SEMI) begin
						st_d = ST_COMMENT;
					end else if (cur_byte == CH_BSL) begin
						st_d = ST_SECTION;
					end else if (cur_byte == CH_EQ) begin
						st_d = ST_VALUE;
					end else if (cur_byte == CH_AT) begin
						st_d    = ST_SIGNATURE;
						cnt_d   = 4'd0;
						match_d = 1'b1;
					end else if (cur_byte != CH_RBR) begin
						st_d = ST_FIELD;
					end
				end
				ST_COMMENT: begin
					if (is_eol) st_d = ST_BEGIN;
				end
				ST_SECTION: begin
					if (cur_byte == CH_LBR || is_blank || is_eol) st_d = ST_BEGIN;
				end
				ST_FIELD: begin
					if (cur_byte == CH_EQ || is_blank) st_d = ST_BEGIN;
				end
				ST_VALUE: begin
					if (cur_byte == CH_BSL) st_d = ST_VALUE_ESC;
					else if (is_eol) st_d = ST_BEGIN;
				end
				ST_VALUE_ESC: begin
					st_d = is_eol ? ST_VALUE_JOIN : ST_VALUE;
				end
				ST_VALUE_JOIN: begin
					if (!is_eol) st_d = ST_VALUE;
				end
				ST_SIGNATURE: begin
					if (idx == SIG_LAST_IDX) begin
						st_d    = ST_BEGIN;
						cnt_d   = 4'd0;
						match_d = 1'b1;
					end else begin
						cnt_d   = idx + 4'd1;
						match_d = match_q && sig_hit;
					end
				end
				default: st_d = ST_BEGIN;
			endcase
		end
	end

	always_comb begin
		res = '0;
		if (abort) begin
			res.num   = 2'd1;
			res.r0.ev = EV_ABORTED;
		end else begin
			case (st_q)
				ST_BEGIN: begin
					if (is_blank || is_eol || cur_byte == CH_SEMI || cur_byte == CH_BSL
					    || cur_byte == CH_EQ || cur_byte == CH_AT) begin
						res.num = 2'd0;
					end else if (cur_byte == CH_RBR) begin
						res.num   = 2'd1;
						res.r0.ev = EV_END_SECTION;
					end else begin
						res.num     = 2'd1;
						res.r0.ev   = EV_FIELD_BYTE;
						res.r0.data = cur_byte;
					end
				end
				ST_COMMENT: res.num = 2'd0;
				ST_SECTION: begin
					res.num = 2'd1;
					if (cur_byte == CH_LBR || is_blank || is_eol) begin
						res.r0.ev = EV_SECTION_DONE;
					end else begin
						res.r0.ev   = EV_SECTION_BYTE;
						res.r0.data = cur_byte;
					end
				end
				ST_FIELD: begin
					res.num = 2'd1;
					if (cur_byte == CH_EQ || is_blank) begin
						res.r0.ev = EV_FIELD_DONE;
					end else begin
						res.r0.ev   = EV_FIELD_BYTE;
						res.r0.data = cur_byte;
					end
				end
				ST_VALUE: begin
					if (cur_byte == CH_BSL) begin
						res.num = 2'd0;
					end else if (is_eol) begin
						res.num   = 2'd1;
						res.r0.ev = EV_VALUE_DONE;
					end else begin
						res.num     = 2'd1;
						res.r0.ev   = EV_VALUE_BYTE;
						res.r0.data = cur_byte;
					end
				end
				ST_VALUE_ESC: begin
					if (!is_eol) begin
						res.num     = 2'd2;
						res.r0.ev   = EV_VALUE_BYTE;
						res.r0.data = CH_BSL;
						res.r1.ev   = EV_VALUE_BYTE;
						res.r1.data = cur_byte;
					end
				end
				ST_VALUE_JOIN: begin
					if (!is_eol) begin
						res.num     = 2'd1;
						res.r0.ev   = EV_VALUE_BYTE;
						res.r0.data = cur_byte;
					end
				end
				ST_SIGNATURE: begin
					if (idx == SIG_LAST_IDX) begin
						res.num   = 2'd1;
						res.r0.ev = (match_q && sig_hit) ? EV_SIG_OK : EV_SIG_BAD;
					end
				end
				default: res.num = 2'd0;
			endcase
		end
		res.r0.last = (res.num == 2'd1);
		res.r1.last = (res.num == 2'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_BEGIN;
			cnt_q   <= 4'd0;
			match_q <= 1'b1;
		end else if (adv) begin
			st_q    <= st_d;
			cnt_q   <= cnt_d;
			match_q <= match_d;
		end
	end

endmodule

FILE: src/stt_queue.sv
`timescale 1ns / 1ps

module stt_queue import stt_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  result_pair_t  wr,
	input  logic          pop,
	output logic          not_empty,
	output result_t       head,
	output queue_status_t status
);

	result_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr1;
	logic [QCNT_W-1:0] cnt_q, n_push;
	logic              do_pop;

	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;
	assign n_push    = push ? QCNT_W'(wr.num) : '0;
	assign wr_ptr1   = wr_ptr_q + QPTR_W'(1);

	// Room for a worst-case byte, judged on the registered count only.
	assign status.room  = (cnt_q <= QCNT_W'(QUEUE_DEPTH - 2));
	assign status.count = cnt_q;

	always_ff @(posedge clk) begin
		if (push && wr.num != 2'd0) mem_q[wr_ptr_q] <= wr.r0;
		if (push && wr.num == 2'd2) mem_q[wr_ptr1] <= wr.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(n_push);
			if (do_pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			cnt_q <= cnt_q + n_push - QCNT_W'(do_pop);
		end
	end

endmodule

FILE: src/sectioned_text_tokenizer_unit.sv
`timescale 1ns / 1ps
// A byte is registered on acceptance and its results enter the four-entry output queue
// once that queue has room for a worst-case byte; the first result is offered at its head.
// Throughput: one byte per cycle while the queue has room; the output side moves one
// result per cycle while out_stall is low, and an escaped value byte gives two results.
// Reset: arst_n clears the parser to the begin state and empties the queue.
module sectioned_text_tokenizer_unit import stt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] event_res,
	output logic [7:0] out_byte,
	output logic       last
);

	logic          valid_s1, adv;
	logic [7:0]    byte_s1;
	result_pair_t  res;
	result_t       head;
	queue_status_t qstat;

	assign adv      = valid_s1 && qstat.room;
	assign in_stall = valid_s1 && !qstat.room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) byte_s1 <= in_byte;
	end

	stt_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.cur_byte (byte_s1),
		.res      (res)
	);

	stt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (adv),
		.wr        (res),
		.pop       (!out_stall),
		.not_empty (out_valid),
		.head      (head),
		.status    (qstat)
	);

	assign event_res = head.ev;
	assign out_byte  = head.data;
	assign last      = head.last;

`ifndef ASSERT_OFF
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.count <= QCNT_W'(QUEUE_DEPTH))
		else $error("result queue overflow");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && !qstat.room))
		else $error("input stalled with no held byte");

	a_held_result_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("pending result dropped while stalled");
`endif

endmodule
